// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the min/max column decimator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MMCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define MMCD_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/mmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcd_pkg
// Types and constants shared by the min/max column decimator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mmcd_pkg;

   localparam int MaxColumnsDefault = 300;
   localparam int MaxSamplesDefault = 8192;

   localparam int RowMax  = 17;
   localparam int RowW    = 5;
   localparam int ProdW   = 29;
   localparam int RowTop  = RowMax * 65536 + 32768;

   localparam int ColW    = 9;
   localparam int StepW   = 30;
   localparam int CodeW   = 8;
   localparam int ScaleW  = 21;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 30;

   localparam logic [CsrIdxW-1:0] CsrColumnCount = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrColumnStep  = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrFloorValue  = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrValueSpan   = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrRowScale    = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrNoneCode    = 3'd5;

   localparam logic [ColW-1:0]   ResetColumnCount = 9'd280;
   localparam logic [StepW-1:0]  ResetColumnStep  = 30'd1912670;
   localparam logic [CodeW-1:0]  ResetFloorValue  = 8'd2;
   localparam logic [CodeW-1:0]  ResetValueSpan   = 8'd250;
   localparam logic [ScaleW-1:0] ResetRowScale    = 21'd4456;
   localparam logic [CodeW-1:0]  ResetNoneCode    = 8'd0;

   localparam logic [StepW-1:0]  StepOne = 30'd65536;

   typedef struct packed {
      logic [CodeW-1:0]  floor_value;
      logic [CodeW-1:0]  value_span;
      logic [ScaleW-1:0] row_scale;
      logic [CodeW-1:0]  none_code;
   } map_cfg_type;

   typedef struct packed {
      logic [ColW-1:0]  column;
      logic [CodeW-1:0] upper;
      logic [CodeW-1:0] lower;
      logic             last;
   } col_type;

endpackage

`default_nettype wire

// ===== sv/mmcd_rowmap.sv =====
// ----------------------------------------------------------------------------
// mmcd_rowmap
// Maps one sample code to a pixel row, or flags it as a missing point.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcd_rowmap (
   input  wire logic [mmcd_pkg::CodeW-1:0] code,
   input  wire mmcd_pkg::map_cfg_type      cfg,
   output logic [mmcd_pkg::RowW-1:0]       row,
   output logic                            missing
);
   import mmcd_pkg::*;

   logic [CodeW-1:0] diff;
   logic [CodeW-1:0] d;
   logic [ProdW-1:0] prod;
   logic [ProdW-1:0] t;
   logic [ProdW-17:0] tq;

   always_comb begin
      missing = (code == cfg.none_code);
      diff    = code - cfg.floor_value;
      if (code < cfg.floor_value) begin
         d = '0;
      end else if (diff > cfg.value_span) begin
         d = cfg.value_span;
      end else begin
         d = diff;
      end
      prod = ProdW'(cfg.row_scale) * ProdW'(d);
      t    = ProdW'(RowTop) - prod;
      tq   = t[ProdW-1:16];
      if (missing || (prod > ProdW'(RowTop))) begin
         row = '0;
      end else if (tq > (ProdW-16)'(RowMax)) begin
         row = RowW'(RowMax);
      end else begin
         row = tq[RowW-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== sv/mmcd_track.sv =====
// ----------------------------------------------------------------------------
// mmcd_track
// Column tracking: sample and column counters, running min/max, widening
// toward the previous column, and the register holding a finished column.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mmcd_track #(
   parameter int MaxColumns = mmcd_pkg::MaxColumnsDefault,
   parameter int MaxSamples = mmcd_pkg::MaxSamplesDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [mmcd_pkg::CodeW-1:0]  sample,
   input  wire logic                        frame_start,
   input  wire logic                        advance,
   input  wire logic [mmcd_pkg::ColW-1:0]   column_count,
   input  wire logic [mmcd_pkg::StepW-1:0]  column_step,
   output logic                             col_valid,
   output mmcd_pkg::col_type                col
);
   import mmcd_pkg::*;

   localparam int SIdxW  = $clog2(MaxSamples + 1);
   localparam int CIdxW  = $clog2(MaxColumns + 1);
   localparam int AccW   = StepW + CIdxW;
   localparam int FirstW = AccW - 16;
   localparam int LastW  = FirstW + 1;

   logic [SIdxW-1:0] sample_index_ff, sample_index_in;
   logic [CIdxW-1:0] column_index_ff, column_index_in;
   logic [AccW-1:0]  acc_ff, acc_in;
   logic             in_column_ff, in_column_in;
   logic [CodeW-1:0] run_min_ff, run_min_in, run_max_ff, run_max_in;
   logic [CodeW-1:0] prev_min_ff, prev_min_in, prev_max_ff, prev_max_in;
   logic             col_valid_ff, col_valid_in;
   col_type          col_ff, col_in;

   logic [SIdxW-1:0] sidx;
   logic [CIdxW-1:0] cidx;
   logic [AccW-1:0]  acc;
   logic             inc;
   logic [9:0]       count;
   logic             samp_ok;
   logic             col_ok;
   logic [StepW-1:0] step;
   logic [LastW-1:0] first;
   logic [LastW-1:0] last;
   logic             hit_first;
   logic             in_range;
   logic             emit;

   always_comb begin
      sidx = frame_start ? '0 : sample_index_ff;
      cidx = frame_start ? '0 : column_index_ff;
      acc  = frame_start ? '0 : acc_ff;
      inc  = frame_start ? 1'b0 : in_column_ff;

      count   = ({1'b0, column_count} > 10'(MaxColumns)) ? 10'(MaxColumns)
                                                        : {1'b0, column_count};
      samp_ok = (sidx < SIdxW'(MaxSamples));
      col_ok  = (10'(cidx) < count);
      step    = (column_step < StepOne) ? StepOne : column_step;
      first   = LastW'(acc[AccW-1:16]);
      last    = first + LastW'(step[StepW-1:16]) - LastW'(1);

      hit_first = (LastW'(sidx) == first);
      in_range  = (LastW'(sidx) <= last);

      sample_index_in = samp_ok ? sidx + SIdxW'(1) : sidx;
      column_index_in = cidx;
      acc_in          = acc;
      in_column_in    = inc;
      run_min_in      = run_min_ff;
      run_max_in      = run_max_ff;
      prev_min_in     = prev_min_ff;
      prev_max_in     = prev_max_ff;
      emit            = 1'b0;

      col_in.column = ColW'(cidx);
      col_in.last   = ((10'(cidx) + 10'd1) == count);
      col_in.upper  = '0;
      col_in.lower  = '0;

      if (samp_ok && col_ok) begin
         if (hit_first) begin
            run_min_in   = sample;
            run_max_in   = sample;
            in_column_in = 1'b1;
         end else if (inc && in_range) begin
            if (sample < run_min_ff) begin
               run_min_in = sample;
            end
            if (sample > run_max_ff) begin
               run_max_in = sample;
            end
         end

         emit = in_column_in && (LastW'(sidx) == last);

         if (cidx == '0) begin
            col_in.upper = run_max_in;
            col_in.lower = run_min_in;
         end else begin
            col_in.upper = (run_max_in < prev_min_ff) ? prev_min_ff : run_max_in;
            col_in.lower = (run_min_in > prev_max_ff) ? prev_max_ff : run_min_in;
         end

         if (emit) begin
            prev_min_in     = run_min_in;
            prev_max_in     = run_max_in;
            column_index_in = cidx + CIdxW'(1);
            acc_in          = acc + AccW'(step);
            in_column_in    = 1'b0;
         end
      end

      if (accept) begin
         col_valid_in = emit;
      end else if (advance) begin
         col_valid_in = 1'b0;
      end else begin
         col_valid_in = col_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         column_index_ff <= '0;
         acc_ff          <= '0;
         in_column_ff    <= 1'b0;
         run_min_ff      <= '0;
         run_max_ff      <= '0;
         prev_min_ff     <= '0;
         prev_max_ff     <= '0;
         col_valid_ff    <= 1'b0;
      end else begin
         col_valid_ff <= col_valid_in;
         if (accept) begin
            sample_index_ff <= sample_index_in;
            column_index_ff <= column_index_in;
            acc_ff          <= acc_in;
            in_column_ff    <= in_column_in;
            run_min_ff      <= run_min_in;
            run_max_ff      <= run_max_in;
            prev_min_ff     <= prev_min_in;
            prev_max_ff     <= prev_max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         col_ff <= col_in;
      end
   end

   assign col_valid = col_valid_ff;
   assign col       = col_ff;

   `MMCD_ASSERT(a_col_from_accept, clock, reset,
      (col_valid_ff && !$past(col_valid_ff)) |-> $past(accept), "column without sample")
   `MMCD_ASSERT(a_col_index_range, clock, reset,
      col_valid_ff |-> (10'(col_ff.column) < 10'(MaxColumns)), "column index out of range")

endmodule

`default_nettype wire

// ===== sv/minmax_column_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// minmax_column_decimator_unit
// Min/max peak decimation of a sample record into display columns.
// ----------------------------------------------------------------------------
// The unit takes one 8-bit sample per clock and emits one beat per finished
// display column, carrying the pixel rows of the column's widened upper and
// lower values. A sample passes through two register stages: the column
// tracker (counters, running min/max and a Q23.16 column start adder) and
// the row mapper (clamp, one 21x8 multiply and saturation) feeding the output
// register. The input takes a beat every cycle while the output is being
// drained; a stalled output holds back input once both stages are full.
// Configuration writes are taken at any time and must only happen while no
// sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module minmax_column_decimator_unit #(
   parameter int MaxColumns = mmcd_pkg::MaxColumnsDefault,
   parameter int MaxSamples = mmcd_pkg::MaxSamplesDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mmcd_pkg::CodeW-1:0]    req_sample,
   input  wire logic                          req_frame_start,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mmcd_pkg::ColW-1:0]          rsp_column,
   output logic [mmcd_pkg::RowW-1:0]          rsp_row_high,
   output logic [mmcd_pkg::RowW-1:0]          rsp_row_low,
   output logic                               rsp_high_missing,
   output logic                               rsp_low_missing,
   output logic                               rsp_last_column,

   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mmcd_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [mmcd_pkg::CsrW-1:0]     csr_wdata
);
   import mmcd_pkg::*;

   logic [ColW-1:0]   column_count_ff;
   logic [StepW-1:0]  column_step_ff;
   map_cfg_type       map_cfg_ff;

   logic              col_valid;
   col_type           col;
   logic              advance;
   logic              accept;

   logic [RowW-1:0]   row_high;
   logic [RowW-1:0]   row_low;
   logic              high_missing;
   logic              low_missing;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ColW-1:0]   column_ff;
   logic [RowW-1:0]   row_high_ff, row_low_ff;
   logic              high_missing_ff, low_missing_ff, last_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff        <= ResetColumnCount;
         column_step_ff         <= ResetColumnStep;
         map_cfg_ff.floor_value <= ResetFloorValue;
         map_cfg_ff.value_span  <= ResetValueSpan;
         map_cfg_ff.row_scale   <= ResetRowScale;
         map_cfg_ff.none_code   <= ResetNoneCode;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrColumnCount: column_count_ff        <= csr_wdata[ColW-1:0];
            CsrColumnStep:  column_step_ff         <= csr_wdata[StepW-1:0];
            CsrFloorValue:  map_cfg_ff.floor_value <= csr_wdata[CodeW-1:0];
            CsrValueSpan:   map_cfg_ff.value_span  <= csr_wdata[CodeW-1:0];
            CsrRowScale:    map_cfg_ff.row_scale   <= csr_wdata[ScaleW-1:0];
            CsrNoneCode:    map_cfg_ff.none_code   <= csr_wdata[CodeW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset && (!col_valid || advance);
   assign accept    = req_valid && req_ready;

   mmcd_track #(
      .MaxColumns (MaxColumns),
      .MaxSamples (MaxSamples)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .sample       (req_sample),
      .frame_start  (req_frame_start),
      .advance      (advance),
      .column_count (column_count_ff),
      .column_step  (column_step_ff),
      .col_valid    (col_valid),
      .col          (col)
   );

   mmcd_rowmap u_map_high (
      .code    (col.upper),
      .cfg     (map_cfg_ff),
      .row     (row_high),
      .missing (high_missing)
   );

   mmcd_rowmap u_map_low (
      .code    (col.lower),
      .cfg     (map_cfg_ff),
      .row     (row_low),
      .missing (low_missing)
   );

   assign rsp_valid_in = advance ? col_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && col_valid) begin
         column_ff       <= col.column;
         row_high_ff     <= row_high;
         row_low_ff      <= row_low;
         high_missing_ff <= high_missing;
         low_missing_ff  <= low_missing;
         last_ff         <= col.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column       = column_ff;
   assign rsp_row_high     = row_high_ff;
   assign rsp_row_low      = row_low_ff;
   assign rsp_high_missing = high_missing_ff;
   assign rsp_low_missing  = low_missing_ff;
   assign rsp_last_column  = last_ff;

   `MMCD_ASSERT(a_row_range, clock, reset,
      rsp_valid |-> (rsp_row_high <= RowW'(RowMax)) && (rsp_row_low <= RowW'(RowMax)),
      "row beyond lowest pixel row")
   `MMCD_NEVER(a_missing_row, clock, reset,
      rsp_valid && ((rsp_high_missing && (rsp_row_high != '0)) ||
      (rsp_low_missing && (rsp_row_low != '0))), "missing point with nonzero row")
   `MMCD_ASSERT(a_out_from_stage, clock, reset,
      $rose(rsp_valid) |-> $past(col_valid), "output beat without finished column")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the min/max column decimator unit.
// ----------------------------------------------------------------------------
// Sample records are streamed into the unit under several register settings,
// among them the extremes and the corner settings (zero columns, a step below
// one sample, saturating scales, oversized column counts). The sender and the
// receiver idle at random in several phases. One long hold-off on the
// receiver fills the pipeline so that it stalls its input. Every column beat
// is compared field by field with the column that the testbench works out
// for each accepted sample.
// ----------------------------------------------------------------------------

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned SettleCycles = 8;
   localparam logic [mmcd_pkg::CsrIdxW-1:0] CsrSpareLow  = 3'd6;
   localparam logic [mmcd_pkg::CsrIdxW-1:0] CsrSpareHigh = 3'd7;

   typedef struct {
      logic [mmcd_pkg::ColW-1:0] column;
      logic [mmcd_pkg::RowW-1:0] row_high;
      logic [mmcd_pkg::RowW-1:0] row_low;
      logic                      high_missing;
      logic                      low_missing;
      logic                      last_column;
   } column_beat_type;

   class column_decimation;
      logic [mmcd_pkg::ColW-1:0]   count_reg = mmcd_pkg::ResetColumnCount;
      logic [mmcd_pkg::StepW-1:0]  step_reg  = mmcd_pkg::ResetColumnStep;
      logic [mmcd_pkg::CodeW-1:0]  floor_reg = mmcd_pkg::ResetFloorValue;
      logic [mmcd_pkg::CodeW-1:0]  span_reg  = mmcd_pkg::ResetValueSpan;
      logic [mmcd_pkg::ScaleW-1:0] scale_reg = mmcd_pkg::ResetRowScale;
      logic [mmcd_pkg::CodeW-1:0]  none_reg  = mmcd_pkg::ResetNoneCode;

      int unsigned       sample_index = 0;
      int unsigned       column_index = 0;
      longint unsigned   start_acc = 0;
      logic [7:0]        run_min = 0, run_max = 0, prev_min = 0, prev_max = 0;
      bit                in_col = 0;

      column_beat_type   pending_columns[$];
      int unsigned       mismatches = 0;

      function void write_reg(logic [mmcd_pkg::CsrIdxW-1:0] idx,
                              logic [mmcd_pkg::CsrW-1:0] data);
         case (idx)
            mmcd_pkg::CsrColumnCount: count_reg = data[mmcd_pkg::ColW-1:0];
            mmcd_pkg::CsrColumnStep:  step_reg  = data[mmcd_pkg::StepW-1:0];
            mmcd_pkg::CsrFloorValue:  floor_reg = data[mmcd_pkg::CodeW-1:0];
            mmcd_pkg::CsrValueSpan:   span_reg  = data[mmcd_pkg::CodeW-1:0];
            mmcd_pkg::CsrRowScale:    scale_reg = data[mmcd_pkg::ScaleW-1:0];
            mmcd_pkg::CsrNoneCode:    none_reg  = data[mmcd_pkg::CodeW-1:0];
            default: ;
         endcase
      endfunction

      function void code_to_row(input logic [7:0] code,
                                output logic [mmcd_pkg::RowW-1:0] row,
                                output logic missing);
         longint d, t;
         if (code == none_reg) begin
            row = '0;
            missing = 1'b1;
            return;
         end
         missing = 1'b0;
         d = longint'(code) - longint'(floor_reg);
         if (d < 0) d = 0;
         if (d > longint'(span_reg)) d = longint'(span_reg);
         t = longint'(mmcd_pkg::RowTop) - longint'(scale_reg) * d;
         if (t < 0) t = 0;
         t = t / 65536;
         if (t > mmcd_pkg::RowMax) t = mmcd_pkg::RowMax;
         row = mmcd_pkg::RowW'(t);
      endfunction

      function void take_sample(logic [7:0] code, logic start);
         int unsigned     idx, count;
         longint unsigned step, len, first, last;
         logic [7:0]      upper, lower;
         column_beat_type beat;
         if (start) begin
            sample_index = 0;
            column_index = 0;
            start_acc = 0;
            in_col = 0;
         end
         if (sample_index >= mmcd_pkg::MaxSamplesDefault) return;
         idx = sample_index;
         sample_index++;
         count = (count_reg < mmcd_pkg::MaxColumnsDefault) ? count_reg
                                                           : mmcd_pkg::MaxColumnsDefault;
         if (column_index >= count) return;
         step = (step_reg < mmcd_pkg::StepOne) ? mmcd_pkg::StepOne : step_reg;
         len = step >> 16;
         first = start_acc >> 16;
         last = first + len - 1;
         if (idx == first) begin
            run_min = code;
            run_max = code;
            in_col = 1;
         end else if (in_col && idx <= last) begin
            if (code < run_min) run_min = code;
            if (code > run_max) run_max = code;
         end
         if (in_col && idx == last) begin
            if (column_index == 0) begin
               upper = run_max;
               lower = run_min;
            end else begin
               upper = (run_max < prev_min) ? prev_min : run_max;
               lower = (run_min > prev_max) ? prev_max : run_min;
            end
            beat.column = mmcd_pkg::ColW'(column_index);
            code_to_row(upper, beat.row_high, beat.high_missing);
            code_to_row(lower, beat.row_low, beat.low_missing);
            beat.last_column = (column_index + 1 == count);
            pending_columns.push_back(beat);
            prev_min = run_min;
            prev_max = run_max;
            column_index++;
            start_acc += step;
            in_col = 0;
         end
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void match_column(logic [mmcd_pkg::ColW-1:0] column,
                                 logic [mmcd_pkg::RowW-1:0] row_high,
                                 logic [mmcd_pkg::RowW-1:0] row_low,
                                 logic high_missing, logic low_missing,
                                 logic last_column);
         column_beat_type want;
         if (pending_columns.size() == 0) begin
            $error("column beat %0d arrived with no column outstanding", column);
            mismatches++;
            return;
         end
         want = pending_columns.pop_front();
         check_field("column", want.column, column);
         check_field("row_high", want.row_high, row_high);
         check_field("row_low", want.row_low, row_low);
         check_field("high_missing", want.high_missing, high_missing);
         check_field("low_missing", want.low_missing, low_missing);
         check_field("last_column", want.last_column, last_column);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [mmcd_pkg::CodeW-1:0]      req_sample = '0;
   logic                            req_frame_start = 1'b0;

   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mmcd_pkg::ColW-1:0]       rsp_column;
   logic [mmcd_pkg::RowW-1:0]       rsp_row_high;
   logic [mmcd_pkg::RowW-1:0]       rsp_row_low;
   logic                            rsp_high_missing;
   logic                            rsp_low_missing;
   logic                            rsp_last_column;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [mmcd_pkg::CsrIdxW-1:0]    csr_index = '0;
   logic [mmcd_pkg::CsrW-1:0]       csr_wdata = '0;

   column_decimation cols = new();
   int unsigned      send_idle_pct = 0;
   int unsigned      stall_pct = 0;
   logic             rsp_hold = 1'b0;
   int unsigned      cycle_count = 0;

   minmax_column_decimator_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column       (rsp_column),
      .rsp_row_high     (rsp_row_high),
      .rsp_row_low      (rsp_row_low),
      .rsp_high_missing (rsp_high_missing),
      .rsp_low_missing  (rsp_low_missing),
      .rsp_last_column  (rsp_last_column),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         cols.match_column(rsp_column, rsp_row_high, rsp_row_low,
                           rsp_high_missing, rsp_low_missing, rsp_last_column);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_sample(input logic [7:0] code, input logic start);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_sample <= code;
      req_frame_start <= start;
      do @(posedge clock); while (!req_ready);
      cols.take_sample(code, start);
   endtask

   task automatic write_csr(input logic [mmcd_pkg::CsrIdxW-1:0] idx,
                            input logic [mmcd_pkg::CsrW-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cols.write_reg(idx, data);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (cols.pending_columns.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
         1: begin
            send_idle_pct = 69;
            stall_pct <= 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct <= 69;
         end
         default: begin
            send_idle_pct = 9;
            stall_pct <= 9;
         end
      endcase
   endtask

   task automatic program_settings(input logic [8:0] count, input logic [29:0] step,
                                   input logic [7:0] floor_code, input logic [7:0] span,
                                   input logic [20:0] scale, input logic [7:0] none);
      write_csr(mmcd_pkg::CsrColumnCount, (30'($urandom) << 9) | 30'(count));
      write_csr(mmcd_pkg::CsrColumnStep, step);
      write_csr(mmcd_pkg::CsrFloorValue, (30'($urandom) << 8) | 30'(floor_code));
      write_csr(mmcd_pkg::CsrValueSpan, (30'($urandom) << 8) | 30'(span));
      write_csr(mmcd_pkg::CsrRowScale, (30'($urandom) << 21) | 30'(scale));
      write_csr(mmcd_pkg::CsrNoneCode, (30'($urandom) << 8) | 30'(none));
   endtask

   task automatic program_random_settings();
      logic [8:0]  count;
      logic [29:0] step;
      logic [7:0]  floor_code, span, none;
      logic [20:0] scale;
      case ($urandom_range(9))
         0: count = '0;
         1: count = 9'($urandom_range(300, 511));
         default: count = 9'($urandom_range(1, 12));
      endcase
      case ($urandom_range(9))
         0: step = 30'($urandom_range(0, 65535));
         1: step = 30'($urandom_range(8 * 65536, 30'h3FFFFFFF));
         default: step = 30'($urandom_range(65536, 4 * 65536));
      endcase
      floor_code = 8'($urandom);
      span = 8'($urandom);
      case ($urandom_range(5))
         0: scale = 21'($urandom);
         1: scale = ($urandom_range(1) == 0) ? 21'h0 : 21'h1FFFFF;
         default: scale = (span == 0) ? 21'h10000
                                      : 21'((17 * 65536) / span + $urandom_range(0, 64));
      endcase
      none = ($urandom_range(3) == 0) ? floor_code : 8'($urandom);
      program_settings(count, step, floor_code, span, scale, none);
      if ($urandom_range(3) == 0) begin
         write_csr($urandom_range(1) ? CsrSpareLow : CsrSpareHigh, 30'($urandom));
      end
   endtask

   task automatic send_codes(input logic [7:0] codes[$], input logic restart);
      foreach (codes[k]) send_sample(codes[k], restart && k == 0);
   endtask

   task automatic send_record(input int length, input bit with_start);
      logic [7:0] code;
      logic       start;
      for (int k = 0; k < length; k++) begin
         case ($urandom_range(7))
            0: code = cols.none_reg;
            1: code = cols.floor_reg + 8'($urandom_range(3));
            default: code = 8'($urandom);
         endcase
         start = (with_start && k == 0) || $urandom_range(24) == 0;
         send_sample(code, start);
      end
   endtask

   initial begin
      logic [7:0] codes[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, and a record that begins without a frame start.
      codes = {8'd0, 8'd255, 8'd1, 8'd2, 8'd253, 8'd252, 8'd3, 8'd128};
      send_codes(codes, 1'b0);
      repeat (22) send_sample(8'($urandom), 1'b0);
      settle();

      // Zero span, full scale, skipped sample and samples after the last column.
      program_settings(9'd3, 30'h28000, 8'd10, 8'd0, 21'h1FFFFF, 8'd255);
      write_csr(CsrSpareLow, 30'($urandom));
      write_csr(CsrSpareHigh, 30'h3FFFFFFF);
      codes = {8'd255, 8'd0, 8'd9, 8'd10, 8'd200, 8'd255, 8'd3, 8'd77, 8'd128};
      send_codes(codes, 1'b1);
      settle();

      // Zero columns with the widest step and no scale.
      program_settings(9'd0, 30'h3FFFFFFF, 8'd0, 8'd255, 21'd0, 8'd0);
      codes = {8'd5, 8'd255, 8'd0, 8'd128};
      send_codes(codes, 1'b1);
      settle();

      // Oversized column count and a step below one sample.
      program_settings(9'd511, 30'd100, 8'd0, 8'd255, 21'd4369, 8'd0);
      codes = {8'd1, 8'd255, 8'd0, 8'd40, 8'd200, 8'd0};
      send_codes(codes, 1'b1);
      settle();

      for (int p = 0; p < 14; p++) begin
         set_idling(p % 4);
         settle();
         program_random_settings();
         repeat ($urandom_range(1, 3)) send_record($urandom_range(1, 20),
                                                   $urandom_range(9) != 0);
      end

      // Hold the receiver off while every sample closes a column.
      set_idling(0);
      settle();
      program_settings(9'd300, 30'h10000, 8'd2, 8'd250, 21'd4456, 8'd0);
      rsp_hold <= 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         for (int k = 0; k < 80; k++) send_sample(8'($urandom), k == 0);
      join
      settle();

      // A last record with light idling on both sides.
      set_idling(3);
      send_record(20, 1'b1);
      settle();

      if (cols.mismatches == 0 && cols.pending_columns.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
